FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// widths and types shared by the modular exponentiation unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int DATA_WIDTH = 63;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [DATA_WIDTH:0]   sum_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage

FILE: hdl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base ** exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// Usage: drive in_base, in_exponent and in_modulus and raise start while busy
// is low; the word is taken at that clock edge and busy rises in the next
// cycle unless the modulus is zero. The result appears on out_power_residue
// for exactly one cycle with out_valid high, and busy is already low in that
// cycle, so a new start may be given right then. The receiver cannot stall
// the result. Every modular product runs on one shared modular adder, one
// add and compare per cycle: each multiplier bit takes a doubling step plus
// an adding step when the bit is set, and each product ends with a store and
// a check step.
// Steps: one reduction of the base, then per exponent bit a square and,
// for set bits, a multiply.
// A zero exponent finishes after the reduction alone; a zero modulus gives
// 0 in the cycle after the start.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid; no item in progress survives it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module modular_exponentiation_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mexp_pkg::data_t   in_base,
  input  mexp_pkg::data_t   in_exponent,
  input  mexp_pkg::data_t   in_modulus,
  output logic              out_valid,
  output mexp_pkg::data_t   out_power_residue
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DBL,
    S_ADD,
    S_STORE,
    S_CHK
  } state_t;

  typedef enum logic [1:0] {
    OP_RED,
    OP_MUL,
    OP_SQR
  } op_t;

  localparam int DW = mexp_pkg::DATA_WIDTH;

  state_t           state_r;
  op_t              op_r;
  mexp_pkg::data_t  m_r;
  mexp_pkg::data_t  e_r;
  mexp_pkg::data_t  acc_r;
  mexp_pkg::data_t  sq_r;
  mexp_pkg::data_t  prod_r;
  mexp_pkg::data_t  mx_r;
  mexp_pkg::data_t  my_r;
  mexp_pkg::cnt_t   cnt_r;
  logic             out_valid_r;
  mexp_pkg::data_t  out_res_r;

  // shared modular adder: (prod + b) mod m, both operands below m
  mexp_pkg::data_t  add_b;
  mexp_pkg::sum_t   add_sum;
  mexp_pkg::data_t  add_red;
  mexp_pkg::data_t  add_nxt;
  logic             step_last;
  logic             mul_active;

  always_comb begin
    add_b   = (state_r == S_ADD) ? mx_r : prod_r;
    add_sum = {1'b0, prod_r} + {1'b0, add_b};
    // the difference is below m, so the low bits are exact
    add_red = add_sum[DW-1:0] - m_r;
    add_nxt = (add_sum >= {1'b0, m_r}) ? add_red : add_sum[DW-1:0];
  end

  assign step_last  = (cnt_r == '0);
  assign mul_active = (state_r == S_DBL) || (state_r == S_ADD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_modulus == '0) begin
              out_valid_r <= 1'b1;
              out_res_r   <= '0;
            end else begin
              // base mod m as the product (1 mod m) * base
              m_r     <= in_modulus;
              e_r     <= in_exponent;
              acc_r   <= mexp_pkg::data_t'(in_modulus != mexp_pkg::data_t'(1));
              mx_r    <= mexp_pkg::data_t'(in_modulus != mexp_pkg::data_t'(1));
              my_r    <= in_base;
              prod_r  <= '0;
              cnt_r   <= mexp_pkg::cnt_t'(DW - 1);
              op_r    <= OP_RED;
              state_r <= S_DBL;
            end
          end
        end
        S_DBL: begin
          prod_r <= add_nxt;
          if (my_r[DW-1]) begin
            state_r <= S_ADD;
          end else begin
            my_r  <= {my_r[DW-2:0], 1'b0};
            cnt_r <= cnt_r - 1'b1;
            state_r <= step_last ? S_STORE : S_DBL;
          end
        end
        S_ADD: begin
          prod_r  <= add_nxt;
          my_r    <= {my_r[DW-2:0], 1'b0};
          cnt_r   <= cnt_r - 1'b1;
          state_r <= step_last ? S_STORE : S_DBL;
        end
        S_STORE: begin
          unique case (op_r)
            OP_RED: sq_r  <= prod_r;
            OP_MUL: acc_r <= prod_r;
            OP_SQR: begin
              sq_r <= prod_r;
              e_r  <= {1'b0, e_r[DW-1:1]};
            end
            default: sq_r <= prod_r;
          endcase
          state_r <= S_CHK;
        end
        S_CHK: begin
          prod_r <= '0;
          cnt_r  <= mexp_pkg::cnt_t'(DW - 1);
          mx_r   <= sq_r;
          priority if (op_r == OP_MUL) begin
            my_r    <= sq_r;
            op_r    <= OP_SQR;
            state_r <= S_DBL;
          end else if (e_r == '0) begin
            out_valid_r <= 1'b1;
            out_res_r   <= acc_r;
            state_r     <= S_IDLE;
          end else if (e_r[0]) begin
            my_r    <= acc_r;
            op_r    <= OP_MUL;
            state_r <= S_DBL;
          end else begin
            my_r    <= sq_r;
            op_r    <= OP_SQR;
            state_r <= S_DBL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_power_residue = out_res_r;

  `ASSERT_IMPL(a_prod_reduced, mul_active, (prod_r < m_r && mx_r < m_r), "operand not reduced")
  `ASSERT_NEXT(a_accept_progress, (start && !busy), (busy || out_valid), "word lost at accept")
  `ASSERT_IMPL(a_result_when_idle, out_valid, !busy, "result strobe while still busy")
  `ASSERT_ALWAYS(a_cnt_range, (!mul_active || cnt_r <= mexp_pkg::cnt_t'(DW - 1)), "bad count")

endmodule

FILE: dv/modular_exponentiation_unit_test.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_test
// self-checking bench for base ** exponent mod modulus
// ----------------------------------------------------------------------------
// Words are sent over the start/busy handshake with random hold-offs. Each
// accepted word gets its expected residue from an exact 128-bit predictor,
// and each result strobe is compared against the oldest expected residue.
// Directed tests cover the zero exponent, the zero modulus, a modulus of one
// and the field extremes. A random test then mixes exponent lengths and
// modulus sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modular_exponentiation_unit_test;

  localparam int              HOLD_MAX     = 19;
  localparam int              RANDOM_ITEMS = 100;
  localparam int              CYCLE_LIMIT  = 8_000_000;
  localparam int              TAIL_CYCLES  = 200;
  localparam mexp_pkg::data_t ALL_ONES     = '1;
  localparam mexp_pkg::data_t ONE          = 1;

  logic            clk;
  logic            rst_n       = 1'b0;
  logic            start       = 1'b0;
  mexp_pkg::data_t in_base     = '0;
  mexp_pkg::data_t in_exponent = '0;
  mexp_pkg::data_t in_modulus  = '0;
  logic            busy;
  logic            out_valid;
  mexp_pkg::data_t out_power_residue;

  mexp_pkg::data_t residue_q[$];
  int              error_count = 0;
  int              cycle_count = 0;

  modular_exponentiation_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_base           (in_base),
    .in_exponent       (in_exponent),
    .in_modulus        (in_modulus),
    .out_valid         (out_valid),
    .out_power_residue (out_power_residue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // exact x * y mod m, the product fits in 128 bits
  function automatic mexp_pkg::data_t product_mod(mexp_pkg::data_t x, mexp_pkg::data_t y,
                                                  mexp_pkg::data_t m);
    bit [127:0] wide_x;
    bit [127:0] wide_y;
    bit [127:0] wide_m;
    wide_x = x;
    wide_y = y;
    wide_m = m;
    return mexp_pkg::data_t'((wide_x * wide_y) % wide_m);
  endfunction

  function automatic mexp_pkg::data_t power_mod(mexp_pkg::data_t b, mexp_pkg::data_t e,
                                                mexp_pkg::data_t m);
    mexp_pkg::data_t acc;
    mexp_pkg::data_t sq;
    if (m == '0) begin
      return '0;
    end
    acc = ONE % m;
    sq  = b % m;
    while (e != '0) begin
      if (e[0]) begin
        acc = product_mod(acc, sq, m);
      end
      sq = product_mod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic mexp_pkg::data_t random_word();
    return mexp_pkg::data_t'({$urandom(), $urandom()});
  endfunction

  // random value of at most n bits, n from 0 to 63
  function automatic mexp_pkg::data_t random_bits(int n);
    return random_word() & ((ONE << n) - ONE);
  endfunction

  // random nonzero modulus with its top bit set at a random length
  function automatic mexp_pkg::data_t random_modulus();
    int n;
    n = $urandom_range(1, mexp_pkg::DATA_WIDTH);
    return random_bits(n) | (ONE << (n - 1));
  endfunction

  task automatic report_mismatch(input string what, input mexp_pkg::data_t got,
                                 input mexp_pkg::data_t want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic expect_residue(input mexp_pkg::data_t value);
    residue_q = {residue_q, value};
  endtask

  task automatic send_word(input mexp_pkg::data_t b, input mexp_pkg::data_t e,
                           input mexp_pkg::data_t m);
    int hold;
    bit from_ready;
    hold       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, HOLD_MAX);
    from_ready = ($urandom_range(0, 1) == 1);
    // with no hold-off start stays high into the next word
    if (hold > 0) begin
      start <= 1'b0;
      if (from_ready) begin
        do @(posedge clk); while (busy);
        hold--;
      end
      repeat (hold) @(posedge clk);
    end
    start       <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    in_modulus  <= m;
    do @(posedge clk); while (busy);
    expect_residue(power_mod(b, e, m));
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (residue_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (residue_q.size() == 0) begin
        report_mismatch("unexpected word", out_power_residue, '0);
      end else begin
        mexp_pkg::data_t want;
        want = residue_q.pop_front();
        if (out_power_residue !== want) begin
          report_mismatch("power_residue", out_power_residue, want);
        end
      end
    end
  end

  task automatic test_zero_exponent();
    send_word(mexp_pkg::data_t'(5), '0, ONE);
    send_word('0, '0, mexp_pkg::data_t'(7));
    send_word(ALL_ONES, '0, ALL_ONES);
    send_word(mexp_pkg::data_t'(12345), '0, mexp_pkg::data_t'(2));
    wait_for_results();
  endtask

  task automatic test_zero_modulus();
    send_word(mexp_pkg::data_t'(7), mexp_pkg::data_t'(3), '0);
    send_word(ALL_ONES, ALL_ONES, '0);
    send_word('0, '0, '0);
    wait_for_results();
  endtask

  task automatic test_modulus_one();
    send_word(ALL_ONES, ALL_ONES, ONE);
    send_word(mexp_pkg::data_t'(3), mexp_pkg::data_t'(5), ONE);
    wait_for_results();
  endtask

  task automatic test_edge_values();
    mexp_pkg::data_t mersenne61;
    mexp_pkg::data_t alt_01;
    mexp_pkg::data_t alt_10;
    mersenne61 = (ONE << 61) - ONE;
    alt_01     = mexp_pkg::data_t'({(mexp_pkg::DATA_WIDTH+1)/2{2'b01}});
    alt_10     = mexp_pkg::data_t'({(mexp_pkg::DATA_WIDTH+1)/2{2'b10}});
    send_word('0, mexp_pkg::data_t'(5), mexp_pkg::data_t'(13));
    send_word(ALL_ONES, ONE, ALL_ONES);
    send_word(ALL_ONES - ONE, ALL_ONES, ALL_ONES);
    send_word(ALL_ONES, ALL_ONES, ALL_ONES - ONE);
    send_word(mexp_pkg::data_t'(1000), mexp_pkg::data_t'(3), mexp_pkg::data_t'(7));
    send_word(mexp_pkg::data_t'(2), mexp_pkg::data_t'(10), mexp_pkg::data_t'(1024));
    // fermat: 3 ** (p - 1) mod p is one for the prime 2**61 - 1
    send_word(mexp_pkg::data_t'(3), mersenne61 - ONE, mersenne61);
    send_word(alt_01, alt_10, ALL_ONES);
    wait_for_results();
  endtask

  task automatic test_random();
    mexp_pkg::data_t b;
    mexp_pkg::data_t e;
    mexp_pkg::data_t m;
    int              kind;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          b = random_word();
          e = random_bits($urandom_range(0, mexp_pkg::DATA_WIDTH));
          m = mexp_pkg::data_t'($urandom_range(1, 255));
        end
        1: begin
          b = random_word();
          e = random_word();
          m = random_word();
        end
        2: begin
          b = random_word();
          e = random_bits($urandom_range(0, 8));
          m = ($urandom_range(0, 3) == 0) ? '0 : ALL_ONES;
        end
        default: begin
          b = ($urandom_range(0, 1) == 0) ? random_word()
                                          : random_bits($urandom_range(0, mexp_pkg::DATA_WIDTH));
          e = random_bits($urandom_range(0, mexp_pkg::DATA_WIDTH));
          m = random_modulus();
        end
      endcase
      send_word(b, e, m);
    end
    wait_for_results();
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL modular_exponentiation_unit");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_exponent();
    test_zero_modulus();
    test_modulus_one();
    test_edge_values();
    test_random();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && residue_q.size() == 0) begin
      $display("PASS modular_exponentiation_unit");
    end else begin
      $display("FAIL modular_exponentiation_unit");
    end
    $finish;
  end

endmodule
